// ===== rtl/mte_pkg.sv =====
`default_nettype none

package mte_pkg;

    // code table geometry
    localparam int TABLE_SIZE   = 36;
    localparam int TABLE_AW     = $clog2(TABLE_SIZE);
    localparam int CODE_W       = 8;
    localparam int LETTER_COUNT = 26;

    // element limits: the entry format carries at most five pattern bits
    localparam int MAX_ELEMENTS = 5;
    localparam int PAT_W        = 5;
    localparam int LEN_LIMIT    = (MAX_ELEMENTS < PAT_W) ? MAX_ELEMENTS : PAT_W;

    // led levels and step lengths
    localparam logic [7:0] LED_ON     = 8'd255;
    localparam logic [7:0] LED_OFF    = 8'd0;
    localparam logic [2:0] DUR_IDLE   = 3'd0;
    localparam logic [2:0] DUR_DOT    = 3'd1;
    localparam logic [2:0] DUR_DASH   = 3'd3;
    localparam logic [2:0] LETTER_GAP = 3'd3;
    localparam logic [2:0] WORD_GAP   = 3'd7;

    // ascii codes
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7a;

    typedef struct packed {
        logic                hit;
        logic [TABLE_AW-1:0] idx;
    } symbol_t;

    function automatic symbol_t symbol_index(input logic [7:0] c);
        symbol_t s;
        s.hit = 1'b1;
        s.idx = '0;
        if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
            s.idx = TABLE_AW'(c - CHR_LOWER_A);
        else if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z)
            s.idx = TABLE_AW'(c - CHR_UPPER_A);
        else if (c >= CHR_ZERO && c <= CHR_NINE)
            s.idx = TABLE_AW'(c - CHR_ZERO) + TABLE_AW'(LETTER_COUNT);
        else
            s.hit = 1'b0;
        return s;
    endfunction

    // entry = element count in [7:5], pattern in [4:0], bit i set for a dash
    function automatic logic [CODE_W-1:0] morse_code(input logic [TABLE_AW-1:0] idx);
        logic [CODE_W-1:0] code;
        case (idx)
            6'd0:    code = 8'h42;
            6'd1:    code = 8'h81;
            6'd2:    code = 8'h85;
            6'd3:    code = 8'h61;
            6'd4:    code = 8'h20;
            6'd5:    code = 8'h84;
            6'd6:    code = 8'h63;
            6'd7:    code = 8'h80;
            6'd8:    code = 8'h40;
            6'd9:    code = 8'h8e;
            6'd10:   code = 8'h65;
            6'd11:   code = 8'h82;
            6'd12:   code = 8'h43;
            6'd13:   code = 8'h41;
            6'd14:   code = 8'h67;
            6'd15:   code = 8'h86;
            6'd16:   code = 8'h8b;
            6'd17:   code = 8'h62;
            6'd18:   code = 8'h60;
            6'd19:   code = 8'h21;
            6'd20:   code = 8'h64;
            6'd21:   code = 8'h88;
            6'd22:   code = 8'h66;
            6'd23:   code = 8'h89;
            6'd24:   code = 8'h8d;
            6'd25:   code = 8'h83;
            6'd26:   code = 8'hbf;
            6'd27:   code = 8'hbe;
            6'd28:   code = 8'hbc;
            6'd29:   code = 8'hb8;
            6'd30:   code = 8'hb0;
            6'd31:   code = 8'ha0;
            6'd32:   code = 8'ha1;
            6'd33:   code = 8'ha3;
            6'd34:   code = 8'ha7;
            6'd35:   code = 8'haf;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mte_if.sv =====
`default_nettype none

// text character channel
interface mte_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

// led timing step channel
interface mte_step_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_level;
    logic [2:0] duration_units;
    logic       run_end;

    modport source (output valid, output led_level, output duration_units,
                    output run_end, input ready);
    modport sink   (input valid, input led_level, input duration_units,
                    input run_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/mte_ram.sv =====
`default_nettype none

module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/morse_text_to_led_encoder.sv =====
// morse text to led encoder
//
// text: one ascii character per beat with final_char marking the end of a
// text. steps: led timing steps, led_level 0 or 255 with a duration of 1, 3
// or 7 dot units, duration 0 being the idle marker that closes a text;
// run_end flags the last step caused by a character.
//
// after reset the code table memory is loaded from the package rom; text.ready
// stays low during that pass.
//
// a letter is looked up in the table memory (a registered read), then its steps
// are sequenced one per cycle while steps.ready does not hold the output. after
// its beat the block passes S_READ, then S_LGAP or S_ON, which loads the first
// step of the letter into the output register.
//
// the output register lets a new character be taken while the last step
// still waits; when steps.ready is low the sequencer holds its place.
`default_nettype none

module morse_text_to_led_encoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mte_char_if.sink    text,
    mte_step_if.source  steps
);

    localparam int AW = mte_pkg::TABLE_AW;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_READ,
        S_LGAP,
        S_ON,
        S_OFF,
        S_WGAP,
        S_END
    } state_t;

    state_t                      state_reg,       state_next;
    logic [AW-1:0]               fill_reg,        fill_next;
    logic                        fin_reg,         fin_next;
    logic [2:0]                  len_reg,         len_next;
    logic [mte_pkg::PAT_W-1:0]   pat_reg,         pat_next;
    logic [2:0]                  elem_reg,        elem_next;
    logic                        letter_sent_reg, letter_sent_next;
    logic                        gap_sent_reg,    gap_sent_next;
    logic                        out_valid_reg,   out_valid_next;
    logic [7:0]                  led_level_reg,   led_level_next;
    logic [2:0]                  duration_reg,    duration_next;
    logic                        run_end_reg,     run_end_next;

    // table memory signals
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [mte_pkg::CODE_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [mte_pkg::CODE_W-1:0]  ram_rdata;

    mte_pkg::symbol_t            sym;
    logic                        emit_ok;
    logic                        text_take;
    logic [2:0]                  code_len;
    logic                        last_elem;

    mte_ram #(
        .WIDTH (mte_pkg::CODE_W),
        .DEPTH (mte_pkg::TABLE_SIZE)
    ) u_code_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sym       = mte_pkg::symbol_index(text.character);
    assign text.ready = (state_reg == S_IDLE);
    assign text_take = text.valid && text.ready;

    // output slot is free when empty or being drained this cycle
    assign emit_ok   = !out_valid_reg || steps.ready;

    // element count clamped to what the pattern field can carry
    assign code_len  = (ram_rdata[7:5] > 3'(mte_pkg::LEN_LIMIT))
                       ? 3'(mte_pkg::LEN_LIMIT) : ram_rdata[7:5];
    assign last_elem = (elem_reg == len_reg - 3'd1);

    assign ram_we    = (state_reg == S_FILL);
    assign ram_waddr = fill_reg;
    assign ram_wdata = mte_pkg::morse_code(fill_reg);
    assign ram_raddr = sym.idx;

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        fin_next         = fin_reg;
        len_next         = len_reg;
        pat_next         = pat_reg;
        elem_next        = elem_reg;
        letter_sent_next = letter_sent_reg;
        gap_sent_next    = gap_sent_reg;
        out_valid_next   = out_valid_reg && !steps.ready;
        led_level_next   = led_level_reg;
        duration_next    = duration_reg;
        run_end_next     = run_end_reg;

        unique case (state_reg)
            S_FILL:
            begin
                fill_next = fill_reg + AW'(1);
                if (fill_reg == AW'(mte_pkg::TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (text_take)
                begin
                    fin_next  = text.final_char;
                    elem_next = '0;
                    if (sym.hit)
                    begin
                        // table read is under way, data next cycle
                        state_next = S_READ;
                    end
                    else if (text.character == mte_pkg::CHR_SPACE &&
                             letter_sent_reg && !gap_sent_reg)
                    begin
                        state_next = S_WGAP;
                    end
                    else if (text.final_char)
                    begin
                        state_next = S_END;
                    end
                end
            end

            S_READ:
            begin
                len_next = code_len;
                pat_next = ram_rdata[mte_pkg::PAT_W-1:0];
                if (code_len == 3'd0)
                begin
                    state_next = fin_reg ? S_END : S_IDLE;
                end
                else
                begin
                    state_next       = (letter_sent_reg && !gap_sent_reg) ? S_LGAP : S_ON;
                    letter_sent_next = 1'b1;
                    gap_sent_next    = 1'b0;
                end
            end

            S_LGAP:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    led_level_next = mte_pkg::LED_OFF;
                    duration_next  = mte_pkg::LETTER_GAP;
                    run_end_next   = 1'b0;
                    state_next     = S_ON;
                end
            end

            S_ON:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    led_level_next = mte_pkg::LED_ON;
                    duration_next  = pat_reg[elem_reg] ? mte_pkg::DUR_DASH : mte_pkg::DUR_DOT;
                    run_end_next   = last_elem && !fin_reg;
                    if (last_elem)
                    begin
                        state_next = fin_reg ? S_END : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OFF;
                    end
                end
            end

            S_OFF:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    led_level_next = mte_pkg::LED_OFF;
                    duration_next  = mte_pkg::DUR_DOT;
                    run_end_next   = 1'b0;
                    elem_next      = elem_reg + 3'd1;
                    state_next     = S_ON;
                end
            end

            S_WGAP:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    led_level_next = mte_pkg::LED_OFF;
                    duration_next  = mte_pkg::WORD_GAP;
                    run_end_next   = !fin_reg;
                    gap_sent_next  = 1'b1;
                    state_next     = fin_reg ? S_END : S_IDLE;
                end
            end

            S_END:
            begin
                if (emit_ok)
                begin
                    out_valid_next   = 1'b1;
                    led_level_next   = mte_pkg::LED_OFF;
                    duration_next    = mte_pkg::DUR_IDLE;
                    run_end_next     = 1'b1;
                    letter_sent_next = 1'b0;
                    gap_sent_next    = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_FILL;
            fill_reg        <= '0;
            fin_reg         <= 1'b0;
            len_reg         <= '0;
            pat_reg         <= '0;
            elem_reg        <= '0;
            letter_sent_reg <= 1'b0;
            gap_sent_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            led_level_reg   <= '0;
            duration_reg    <= '0;
            run_end_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            fin_reg         <= fin_next;
            len_reg         <= len_next;
            pat_reg         <= pat_next;
            elem_reg        <= elem_next;
            letter_sent_reg <= letter_sent_next;
            gap_sent_reg    <= gap_sent_next;
            out_valid_reg   <= out_valid_next;
            led_level_reg   <= led_level_next;
            duration_reg    <= duration_next;
            run_end_reg     <= run_end_next;
        end
    end

    assign steps.valid          = out_valid_reg;
    assign steps.led_level      = led_level_reg;
    assign steps.duration_units = duration_reg;
    assign steps.run_end        = run_end_reg;

    // the idle marker always closes the run of its character
    a_idle_marker_ends_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        steps.valid && steps.duration_units == mte_pkg::DUR_IDLE |-> steps.run_end
    ) else $error("idle marker without run_end");

    // a lit step is a dot or a dash
    a_on_is_element: assert property (
        @(posedge clk) disable iff (!rst_n)
        steps.valid && steps.led_level != mte_pkg::LED_OFF |->
            (steps.duration_units == mte_pkg::DUR_DOT ||
             steps.duration_units == mte_pkg::DUR_DASH)
    ) else $error("lit step with bad duration");

    // a word gap is only marked after a letter has been sent
    a_gap_needs_letter: assert property (
        @(posedge clk) disable iff (!rst_n)
        gap_sent_reg |-> letter_sent_reg
    ) else $error("word gap marked without a letter");

    // a new character is never taken before the table load completes
    a_no_take_in_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(state_reg == S_FILL) && state_reg == S_FILL |-> !text_take
    ) else $error("character taken during table load");

endmodule

`default_nettype wire

// ===== tb/mte_step_checker.sv =====
module mte_step_checker (
    input  logic clk,
    input  logic rst_n,
    mte_char_if  text,
    mte_step_if  steps,
    output int   fail_count,
    output int   steps_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import mte_pkg::*;

    typedef struct packed {
        logic [7:0] level;
        logic [2:0] units;
        logic       run_end;
    } led_step_t;

    led_step_t expected_steps [$];
    led_step_t want_step;
    logic      letter_open;
    logic      word_gap_done;
    int        mismatches = 0;

    assign fail_count = mismatches;

    // dots and dashes written out, a-z then 0-9
    function automatic string morse_of(input int slot);
        case (slot)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            25: return "--..";
            26: return "-----";
            27: return ".----";
            28: return "..---";
            29: return "...--";
            30: return "....-";
            31: return ".....";
            32: return "-....";
            33: return "--...";
            34: return "---..";
            35: return "----.";
            default: return "";
        endcase
    endfunction

    function automatic int table_slot(input logic [7:0] c);
        if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
            return int'(c - CHR_LOWER_A);
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z)
            return int'(c - CHR_UPPER_A);
        if (c >= CHR_ZERO && c <= CHR_NINE)
            return int'(c - CHR_ZERO) + LETTER_COUNT;
        return -1;
    endfunction

    // queue up the steps that one text beat should produce
    function automatic void encode_beat(input logic [7:0] c, input logic fin);
        led_step_t run [12];
        int        n;
        int        slot;
        int        k;
        string     code;
        n = 0;
        slot = table_slot(c);
        if (slot >= 0)
        begin
            code = morse_of(slot);
            if (letter_open && !word_gap_done)
            begin
                run[n] = '{LED_OFF, LETTER_GAP, 1'b0};
                n++;
            end
            for (k = 0; k < code.len() && k < MAX_ELEMENTS; k++)
            begin
                if (k > 0)
                begin
                    run[n] = '{LED_OFF, DUR_DOT, 1'b0};
                    n++;
                end
                run[n] = '{LED_ON, (code[k] == "-") ? DUR_DASH : DUR_DOT, 1'b0};
                n++;
            end
            letter_open = 1'b1;
            word_gap_done = 1'b0;
        end
        else if (c == CHR_SPACE && letter_open && !word_gap_done)
        begin
            run[n] = '{LED_OFF, WORD_GAP, 1'b0};
            n++;
            word_gap_done = 1'b1;
        end
        if (fin)
        begin
            run[n] = '{LED_OFF, DUR_IDLE, 1'b0};
            n++;
            letter_open = 1'b0;
            word_gap_done = 1'b0;
        end
        if (n > 0)
            run[n-1].run_end = 1'b1;
        for (k = 0; k < n; k++)
            expected_steps.push_back(run[k]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_open = 1'b0;
            word_gap_done = 1'b0;
            expected_steps.delete();
            steps_due = 0;
        end
        else
        begin
            if (steps.valid && steps.ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $display("%0t unexpected step: expected none,", $time,
                             " got level %0d units %0d end %0b",
                             steps.led_level, steps.duration_units, steps.run_end);
                    mismatches++;
                end
                else
                begin
                    want_step = expected_steps.pop_front();
                    if (steps.led_level !== want_step.level ||
                        steps.duration_units !== want_step.units ||
                        steps.run_end !== want_step.run_end)
                    begin
                        $display("%0t step mismatch: expected level %0d units %0d end %0b,",
                                 $time, want_step.level, want_step.units, want_step.run_end,
                                 " got level %0d units %0d end %0b",
                                 steps.led_level, steps.duration_units, steps.run_end);
                        mismatches++;
                    end
                end
            end
            if (text.valid && text.ready)
                encode_beat(text.character, text.final_char);
            steps_due = expected_steps.size();
        end
    end

endmodule

// ===== tb/tb_morse_text_to_led_encoder.sv =====
module tb_morse_text_to_led_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import mte_pkg::*;

    // random text beats after the directed opening
    localparam int TEXT_BEATS   = 500;
    // far above the slowest legal run, clearing pass included
    localparam int CYCLE_LIMIT  = 200000;
    // idle time after the last expected step, to catch stray steps
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    bit   calm;
    int   cycle_count = 0;
    int   fail_count;
    int   steps_due;

    mte_char_if text_ch ();
    mte_step_if step_ch ();

    morse_text_to_led_encoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .steps (step_ch)
    );

    // watches both channels, predicts the steps and counts mismatches
    mte_step_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text_ch),
        .steps      (step_ch),
        .fail_count (fail_count),
        .steps_due  (steps_due)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one text beat, entered and left at a falling edge; the idle gap before it
    // carries junk on the data lines so that only valid qualifies them
    task automatic send_beat(input logic [7:0] c, input logic fin);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            text_ch.valid      <= 1'b0;
            text_ch.character  <= 8'($urandom_range(0, 255));
            text_ch.final_char <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.character  <= c;
        text_ch.final_char <= fin;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // a run of beats, final_char optionally on the last one
    task automatic send_text(input string s, input logic fin_last);
        int k;
        for (k = 0; k < s.len(); k++)
            send_beat(s[k], fin_last && (k == s.len() - 1));
    endtask

    // mostly letters and digits with word breaks, some arbitrary bytes
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 32)
            return 8'(CHR_LOWER_A + $urandom_range(0, 25));
        if (r < 56)
            return 8'(CHR_UPPER_A + $urandom_range(0, 25));
        if (r < 70)
            return 8'(CHR_ZERO + $urandom_range(0, 9));
        if (r < 88)
            return CHR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // led side: a random stall before each step, none in calm stretches
    initial
    begin
        int stall;
        step_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (stall > 0)
            begin
                step_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            step_ch.ready <= 1'b1;
            @(posedge clk);
            while (!step_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int i;
        rst_n              = 1'b0;
        calm               = 1'b0;
        text_ch.valid      = 1'b0;
        text_ch.character  = 8'h00;
        text_ch.final_char = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // leading spaces give nothing, then a letter gap between two letters
        send_text("  Az", 1'b0);
        // word gap once, repeated spaces and a skipped byte add nothing
        send_text(" #  t", 1'b0);
        // a skipped byte between letters keeps the letter gap; five elements
        send_text("e#5", 1'b0);
        // digits, text closed on a digit
        send_text("09", 1'b1);
        // all-ones and all-zeros bytes; a bare final beat gives only the marker
        send_beat(8'hff, 1'b0);
        send_beat(8'h00, 1'b1);
        // text closed on the space after a letter
        send_text("Q ", 1'b1);
        // text that is nothing but a final space
        send_beat(CHR_SPACE, 1'b1);
        // bytes just outside the letter and digit ranges
        send_text("@[`{/:", 1'b0);

        for (i = 0; i < TEXT_BEATS; i++)
        begin
            // flip between stalling and flat-out stretches now and then
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_beat(pick_char(), $urandom_range(0, 11) == 0);
        end
        text_ch.valid <= 1'b0;

        // let the remaining steps arrive, then watch for strays
        wait (steps_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
